// ===== design/lcg_nextlong_seed_inversion_top_macros.svh =====
// Assertion helpers for the checker of this block.
`ifndef LCG_NEXTLONG_SEED_INVERSION_TOP_MACROS_SVH
`define LCG_NEXTLONG_SEED_INVERSION_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LNSI_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Antecedent implies consequent in the next cycle.
`define LNSI_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== design/lnsi_pkg.sv =====
package lnsi_pkg;

  localparam int unsigned LNSI_QUEUE_DEPTH = 4;

  localparam logic [47:0] LCG_MUL     = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_ADD     = 48'h0000_0000_000B;
  localparam logic [47:0] JUMP_MUL    = 48'd254681119335897;
  localparam logic [47:0] JUMP_ADD    = 48'd120305458776662;
  localparam logic [63:0] LATTICE_OFS = 64'd107048004364969;

  localparam logic [63:0] K_33441 = 64'd33441;
  localparam logic [63:0] K_17549 = 64'd17549;
  localparam logic [63:0] K_46603 = 64'd46603;
  localparam logic [63:0] K_39761 = 64'd39761;
  localparam logic [63:0] K_66882 = 64'd66882;
  localparam logic [63:0] K_35098 = 64'd35098;

  // one queue word: hit count and the low states of the first two hits
  typedef struct packed {
    logic [2:0]  count;
    logic [47:0] state0;
    logic [47:0] state1;
  } lnsi_entry_t;

  // partial products of a 48-bit multiply modulo 2^48
  typedef struct packed {
    logic [47:0] p0;
    logic [23:0] p1;
    logic [23:0] p2;
  } lnsi_part_t;

  function automatic lnsi_part_t lnsi_mul_part(input logic [47:0] a, input logic [47:0] c);
    lnsi_part_t p;
    logic [47:0] t1;
    logic [47:0] t2;
    p.p0 = 48'(a[23:0]) * 48'(c[23:0]);
    t1   = 48'(a[23:0]) * 48'(c[47:24]);
    t2   = 48'(a[47:24]) * 48'(c[23:0]);
    p.p1 = t1[23:0];
    p.p2 = t2[23:0];
    return p;
  endfunction

  function automatic logic [47:0] lnsi_mul_sum(input lnsi_part_t p, input logic [47:0] add);
    logic [23:0] mid;
    mid = p.p1 + p.p2;
    return p.p0 + {mid, 24'd0} + add;
  endfunction

endpackage

// ===== design/lnsi_front.sv =====
module lnsi_front import lnsi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_target_value,
  output logic               push_valid,
  output lnsi_entry_t        push_entry,
  input  logic               queue_full
);

  logic [5:0]  vld_r, vld_nxt;
  logic        en;

  logic [63:0] t_r;
  logic [31:0] lower1_r, lower3_r, lower4_r, lower5_r;
  logic [32:0] upper1_r, upper3_r, upper4_r, upper5_r;
  logic [63:0] lmin_r, lmax_r, umin_r;
  logic [63:0] pa_r, pb_r, pc_r, pd_r;
  logic [31:0] lower2_r;
  logic [32:0] upper2_r;
  logic [63:0] m1_r, m2_r;
  logic [63:0] p1_r, p2_r, q1_r, q2_r;
  logic [63:0] hb_r, lb_r;

  logic [31:0] lower_c;
  logic [32:0] upper_c, lower_inc;
  logic [63:0] ushift, lmax_c, umin_c;
  logic [63:0] sum1, sum2, m1_c, m2_c;
  logic [63:0] hi_st [4];
  logic [63:0] lo_st [4];
  logic [3:0]  hit;
  logic [2:0]  cnt;
  logic [47:0] sel0, sel1;

  assign en         = !(vld_r[5] && queue_full);
  assign in_ready   = en;
  assign push_valid = vld_r[5] && !queue_full;
  assign vld_nxt    = {vld_r[4:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // split halves, correct the upper half for the sign of the low word
  always_comb begin
    lower_c   = t_r[31:0];
    upper_c   = {1'b0, t_r[63:32]} + 33'(t_r[31]);
    lower_inc = {1'b0, lower_c} + 33'd1;
    lmax_c    = {16'd0, lower_inc, 15'd0} - 64'd1;
    ushift    = {15'd0, upper_c, 16'd0} - LATTICE_OFS;
    umin_c    = {ushift[63], ushift[63:1]};
  end

  always_comb begin
    sum1 = pa_r + pb_r;
    sum2 = pc_r + pd_r;
    m1_c = 64'($signed(sum1) >>> 30) + 64'd1;
    m2_c = 64'($signed(sum2) >>> 31) + 64'd1;
  end

  // test the four neighboring lattice points, keep the first two hits
  always_comb begin
    cnt  = '0;
    sel0 = '0;
    sel1 = '0;
    for (int i = 0; i < 4; i++) begin
      hi_st[i] = hb_r + (i[0] ? K_46603 : 64'd0) + (i[1] ? K_66882 : 64'd0);
      lo_st[i] = lb_r + (i[1] ? K_35098 : 64'd0) - (i[0] ? K_39761 : 64'd0);
      hit[i]   = (hi_st[i][63:16] == {15'd0, upper5_r}) &&
                 (lo_st[i][63:16] == {16'd0, lower5_r});
      if (hit[i]) begin
        if (cnt == 3'd0) sel0 = lo_st[i][47:0];
        if (cnt == 3'd1) sel1 = lo_st[i][47:0];
        cnt = cnt + 3'd1;
      end
    end
  end

  assign push_entry = '{count: cnt, state0: sel0, state1: sel1};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= in_target_value;
      lower1_r <= lower_c;
      upper1_r <= upper_c;
      lmin_r   <= {17'd0, lower_c, 15'd0};
      lmax_r   <= lmax_c;
      umin_r   <= umin_c;
      pa_r     <= 64'd0 - 64'(lmax_r * K_33441);
      pb_r     <= 64'(umin_r * K_17549);
      pc_r     <= 64'(lmin_r * K_46603);
      pd_r     <= 64'(umin_r * K_39761);
      lower2_r <= lower1_r;
      upper2_r <= upper1_r;
      m1_r     <= m1_c;
      m2_r     <= m2_c;
      lower3_r <= lower2_r;
      upper3_r <= upper2_r;
      p1_r     <= 64'(m1_r * K_46603);
      p2_r     <= 64'(m2_r * K_66882);
      q1_r     <= 64'(m2_r * K_35098);
      q2_r     <= 64'(m1_r * K_39761);
      lower4_r <= lower3_r;
      upper4_r <= upper3_r;
      hb_r     <= p1_r + p2_r + LATTICE_OFS;
      lb_r     <= q1_r - q2_r;
      lower5_r <= lower4_r;
      upper5_r <= upper4_r;
    end
  end

endmodule

// ===== design/lnsi_queue.sv =====
module lnsi_queue import lnsi_pkg::*; #(
  parameter int unsigned DEPTH = LNSI_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lnsi_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output lnsi_entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lnsi_entry_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    cnt_nxt    = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/lnsi_back.sv =====
module lnsi_back import lnsi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  lnsi_entry_t        head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_match_count,
  output logic signed [63:0] out_first_seed,
  output logic signed [63:0] out_second_seed
);

  logic [5:0]  vld_r, vld_nxt;
  logic        en;
  logic        out_valid_r;
  logic [2:0]  cnt1_r, cnt2_r, cnt3_r, cnt4_r, cnt5_r, cnt6_r, count_r;
  lnsi_part_t  part1_r [2];
  lnsi_part_t  part3_r [2];
  lnsi_part_t  part5_r [2];
  logic [47:0] jump_r [2];
  logic [47:0] hi4_r [2];
  logic [47:0] hi5_r [2];
  logic [47:0] hi6_r [2];
  logic [47:0] lo6_r [2];
  logic [63:0] long_c [2];
  logic [63:0] first_r, second_r;

  assign en      = !out_valid_r || out_ready;
  assign pop     = en;
  assign vld_nxt = {vld_r[4:0], head_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[5];
    end
  end

  // join two 32-bit words of the generator into one 64-bit value
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      long_c[l] = {hi6_r[l][47:16], 32'd0} + {{32{lo6_r[l][47]}}, lo6_r[l][47:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt1_r <= head.count;
      cnt2_r <= cnt1_r;
      cnt3_r <= cnt2_r;
      cnt4_r <= cnt3_r;
      cnt5_r <= cnt4_r;
      cnt6_r <= cnt5_r;
      part1_r[0] <= lnsi_mul_part(head.state0, JUMP_MUL);
      part1_r[1] <= lnsi_mul_part(head.state1, JUMP_MUL);
      for (int l = 0; l < 2; l++) begin
        jump_r[l]  <= lnsi_mul_sum(part1_r[l], JUMP_ADD);
        part3_r[l] <= lnsi_mul_part(jump_r[l], LCG_MUL);
        hi4_r[l]   <= lnsi_mul_sum(part3_r[l], LCG_ADD);
        part5_r[l] <= lnsi_mul_part(hi4_r[l], LCG_MUL);
        hi5_r[l]   <= hi4_r[l];
        lo6_r[l]   <= lnsi_mul_sum(part5_r[l], LCG_ADD);
        hi6_r[l]   <= hi5_r[l];
      end
      count_r  <= cnt6_r;
      first_r  <= (cnt6_r >= 3'd1) ? long_c[0] : 64'd0;
      second_r <= (cnt6_r >= 3'd2) ? long_c[1] : 64'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = count_r;
  assign out_first_seed  = first_r;
  assign out_second_seed = second_r;

endmodule

// ===== design/lcg_nextlong_seed_inversion_top.sv =====
// Inverts a 64-bit nextLong value of the 48-bit LCG back to generator output.
// Input channel: in_valid/in_ready carry one word, in_target_value.
// Output channel: out_valid/out_ready carry one word per input word:
// out_match_count (0 to 4 lattice hits), out_first_seed and out_second_seed
// (nextLong of the first two hits after the backward jump, zero if absent).
// Throughput: one word per cycle while out_ready stays high, with no dependence between words.
// A word passes the lattice stages, the queue and then the three 48-bit
// multiply steps of the back end.
// Each 48-bit multiply is split into 24-bit partial products and a sum stage.
// A small queue separates the lattice front from the multiply back end.
// When out_ready is low the back end holds; the queue then fills and the
// front end stops taking words once its last stage finds the queue full.
// Reset (rst_n low at a clock edge) empties all stages and the queue.
module lcg_nextlong_seed_inversion_top import lnsi_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = LNSI_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_target_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_match_count,
  output logic signed [63:0] out_first_seed,
  output logic signed [63:0] out_second_seed
);

  logic        push_valid, queue_full, queue_not_empty, pop;
  lnsi_entry_t push_entry, head;

  lnsi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_target_value (in_target_value),
    .push_valid      (push_valid),
    .push_entry      (push_entry),
    .queue_full      (queue_full)
  );

  lnsi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  lnsi_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (queue_not_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_count (out_match_count),
    .out_first_seed  (out_first_seed),
    .out_second_seed (out_second_seed)
  );

endmodule

// ===== design/lnsi_checker.sv =====
`include "lcg_nextlong_seed_inversion_top_macros.svh"

module lnsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [63:0] in_target_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_match_count,
  input logic [63:0] out_first_seed,
  input logic [63:0] out_second_seed
);

  // hold a stalled input word
  `LNSI_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_target_value))
  // hold a stalled result word
  `LNSI_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_first_seed))
  `LNSI_IMPLY(a_count_range, out_valid, out_match_count <= 3'd4)
  `LNSI_IMPLY(a_first_zero, out_valid && out_match_count == 3'd0, out_first_seed == 64'd0)
  `LNSI_IMPLY(a_second_zero, out_valid && out_match_count < 3'd2, out_second_seed == 64'd0)

endmodule

bind lcg_nextlong_seed_inversion_top lnsi_checker u_lnsi_checker (.*);
